FILE: rtl/ked_pkg.sv
// shared types, constants and message codes for the key event detector
`timescale 1ns / 1ps
`default_nettype none

package ked_pkg;

  // default build options
  localparam int NUM_KEYS_DEF   = 4;
  localparam int MAX_CLICKS_DEF = 3;

  // width of a key number carried between controller and datapath (up to eight keys)
  localparam int KEY_IDX_W = 3;

  // highest click count that still has a message code of its own
  localparam int CLICK_LIMIT = 3;

  // message codes
  typedef logic [2:0] msg_t;
  localparam msg_t MSG_DOWN   = 3'd0;
  localparam msg_t MSG_UP     = 3'd1;
  localparam msg_t MSG_HOLD   = 3'd2;
  localparam msg_t MSG_REPEAT = 3'd3;
  localparam msg_t MSG_LIFT   = 3'd4;
  localparam msg_t MSG_CLICK1 = 3'd5;

  // register indexes
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_EVENT_ENABLE  = 3'd0;
  localparam reg_idx_t REG_HOLD_TICKS    = 3'd1;
  localparam reg_idx_t REG_REPEAT_TICKS  = 3'd2;
  localparam reg_idx_t REG_RELEASE_TICKS = 3'd3;
  localparam reg_idx_t REG_LIFT_TICKS    = 3'd4;

  // register reset values
  localparam logic [31:0] EVENT_ENABLE_RESET  = 32'd0;
  localparam logic [15:0] HOLD_TICKS_RESET    = 16'd200;
  localparam logic [15:0] REPEAT_TICKS_RESET  = 16'd20;
  localparam logic [15:0] RELEASE_TICKS_RESET = 16'd30;
  localparam logic [15:0] LIFT_TICKS_RESET    = 16'd300;

  typedef struct packed {
    logic [31:0] event_enable;
    logic [15:0] hold_ticks;
    logic [15:0] repeat_ticks;
    logic [15:0] release_ticks;
    logic [15:0] lift_ticks;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_TIME1,
    ST_TIME2,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    STEP_EDGE,
    STEP_TIME1,
    STEP_TIME2
  } step_t;

  typedef struct packed {
    logic                 accept;
    logic                 exec;
    step_t                step;
    logic [KEY_IDX_W-1:0] key;
    logic                 flush;
  } cmd_t;

  typedef struct packed {
    logic slot_ok;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/ked_cfg_regs.sv
// configuration registers of the key event detector
`timescale 1ns / 1ps
`default_nettype none

module ked_cfg_regs (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire ked_pkg::reg_idx_t cfg_index,
  input  wire logic [31:0]       cfg_data,
  output ked_pkg::cfg_t          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.event_enable  <= ked_pkg::EVENT_ENABLE_RESET;
      cfg.hold_ticks    <= ked_pkg::HOLD_TICKS_RESET;
      cfg.repeat_ticks  <= ked_pkg::REPEAT_TICKS_RESET;
      cfg.release_ticks <= ked_pkg::RELEASE_TICKS_RESET;
      cfg.lift_ticks    <= ked_pkg::LIFT_TICKS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ked_pkg::REG_EVENT_ENABLE:  cfg.event_enable  <= cfg_data;
        ked_pkg::REG_HOLD_TICKS:    cfg.hold_ticks    <= cfg_data[15:0];
        ked_pkg::REG_REPEAT_TICKS:  cfg.repeat_ticks  <= cfg_data[15:0];
        ked_pkg::REG_RELEASE_TICKS: cfg.release_ticks <= cfg_data[15:0];
        ked_pkg::REG_LIFT_TICKS:    cfg.lift_ticks    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ked_ctrl.sv
// sequencer: walks the edge pass and the two-step timing pass key by key
`timescale 1ns / 1ps
`default_nettype none

module ked_ctrl #(
  parameter int NUM_KEYS = ked_pkg::NUM_KEYS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ked_pkg::status_t status,
  output ked_pkg::cmd_t         cmd
);

  localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);

  ked_pkg::state_t  state, state_next;
  logic [KEY_W-1:0] key, key_next;
  logic             at_last;

  assign at_last = (key == LAST_KEY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ked_pkg::ST_IDLE;
      key   <= '0;
    end else begin
      state <= state_next;
      key   <= key_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ked_pkg::ST_IDLE:  if (in_valid) state_next = ked_pkg::ST_EDGE;
      ked_pkg::ST_EDGE:  if (status.slot_ok && at_last) state_next = ked_pkg::ST_TIME1;
      ked_pkg::ST_TIME1: if (status.slot_ok) state_next = ked_pkg::ST_TIME2;
      ked_pkg::ST_TIME2: begin
        if (status.slot_ok) state_next = at_last ? ked_pkg::ST_FLUSH : ked_pkg::ST_TIME1;
      end
      ked_pkg::ST_FLUSH: begin
        if (!status.pend_valid || status.out_free) state_next = ked_pkg::ST_IDLE;
      end
      default: state_next = ked_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.exec   = 1'b0;
    cmd.step   = ked_pkg::STEP_EDGE;
    cmd.key    = ked_pkg::KEY_IDX_W'(key);
    cmd.flush  = 1'b0;
    key_next   = key;
    case (state)
      ked_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        key_next   = '0;
      end
      ked_pkg::ST_EDGE: begin
        cmd.exec = status.slot_ok;
        cmd.step = ked_pkg::STEP_EDGE;
        if (status.slot_ok) key_next = at_last ? '0 : key + 1'b1;
      end
      ked_pkg::ST_TIME1: begin
        cmd.exec = status.slot_ok;
        cmd.step = ked_pkg::STEP_TIME1;
      end
      ked_pkg::ST_TIME2: begin
        cmd.exec = status.slot_ok;
        cmd.step = ked_pkg::STEP_TIME2;
        if (status.slot_ok) key_next = at_last ? '0 : key + 1'b1;
      end
      ked_pkg::ST_FLUSH: begin
        cmd.flush = status.pend_valid && status.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/ked_datapath.sv
// per-key state, timing compares, pending message and output register
`timescale 1ns / 1ps
`default_nettype none

module ked_datapath #(
  parameter int NUM_KEYS   = ked_pkg::NUM_KEYS_DEF,
  parameter int MAX_CLICKS = ked_pkg::MAX_CLICKS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ked_pkg::cmd_t  cmd,
  input  wire ked_pkg::cfg_t  cfg,
  input  wire logic [3:0]     key_levels,
  output ked_pkg::status_t    status,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [1:0]          key_index,
  output ked_pkg::msg_t       message,
  output logic                last
);

  localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  function automatic logic enabled(input logic [31:0] ee,
                                   input logic [ked_pkg::KEY_IDX_W-1:0] k,
                                   input ked_pkg::msg_t m);
    logic [4:0] bit_sel;
    bit_sel = {k[1:0], m};
    enabled = k[2] ? 1'b0 : ee[bit_sel];
  endfunction

  // global state
  logic [15:0] tick;
  logic [3:0]  prev_levels;
  logic [3:0]  lvl;
  logic [15:0] age_reg;

  // per-key state
  logic [15:0] change_time  [NUM_KEYS];
  logic [3:0]  press_count  [NUM_KEYS];
  logic        pressed_flag [NUM_KEYS];
  logic        hold_flag    [NUM_KEYS];
  logic        lift_flag    [NUM_KEYS];

  // pending message: held back until the next one shows whether it is the last
  logic          pend_valid;
  logic [1:0]    pend_key;
  ked_pkg::msg_t pend_msg;

  logic [KEY_W-1:0] idx;
  logic [1:0]       key_lo;
  logic             beyond;
  logic             cur, prev;
  logic [3:0]       pc;
  logic [15:0]      ct;
  logic [15:0]      age_now;
  logic [16:0]      rep_sum;
  logic             hold_hit, close_hit, click_ok, rep_hit, lift_hit;
  ked_pkg::msg_t    click_msg;
  ked_pkg::msg_t    emit_msg;
  logic             emit;
  logic             gen;
  logic             out_free;

  assign idx    = cmd.key[KEY_W-1:0];
  assign key_lo = cmd.key[1:0];
  assign beyond = cmd.key[2];

  // keys past the input width read as released
  assign cur  = beyond ? 1'b1 : lvl[key_lo];
  assign prev = beyond ? 1'b1 : prev_levels[key_lo];

  assign pc        = press_count[idx];
  assign ct        = change_time[idx];
  assign age_now   = tick - ct;
  assign rep_sum   = {1'b0, cfg.hold_ticks} + {1'b0, cfg.repeat_ticks};
  assign hold_hit  = enabled(cfg.event_enable, cmd.key, ked_pkg::MSG_HOLD)
                     && !hold_flag[idx] && (age_now >= cfg.hold_ticks);
  assign close_hit = (age_now >= cfg.release_ticks);
  assign click_ok  = !hold_flag[idx] && (pc <= 4'(MAX_CLICKS))
                     && (pc <= 4'(ked_pkg::CLICK_LIMIT));
  assign click_msg = ked_pkg::MSG_CLICK1 + pc[2:0] - 3'd1;
  // the sum bound implies the hold bound
  assign rep_hit   = enabled(cfg.event_enable, cmd.key, ked_pkg::MSG_REPEAT)
                     && ({1'b0, age_reg} >= rep_sum);
  assign lift_hit  = enabled(cfg.event_enable, cmd.key, ked_pkg::MSG_LIFT)
                     && !lift_flag[idx] && (age_reg >= cfg.lift_ticks);

  always_comb begin
    emit     = 1'b0;
    emit_msg = ked_pkg::MSG_DOWN;
    case (cmd.step)
      ked_pkg::STEP_EDGE: begin
        if (cur != prev) begin
          emit_msg = cur ? ked_pkg::MSG_UP : ked_pkg::MSG_DOWN;
          emit     = enabled(cfg.event_enable, cmd.key, emit_msg);
        end
      end
      ked_pkg::STEP_TIME1: begin
        if (pc != 4'd0) begin
          if (pressed_flag[idx]) begin
            emit_msg = ked_pkg::MSG_HOLD;
            emit     = hold_hit;
          end else if (close_hit && click_ok) begin
            emit_msg = click_msg;
            emit     = enabled(cfg.event_enable, cmd.key, click_msg);
          end
        end
      end
      ked_pkg::STEP_TIME2: begin
        if (pc != 4'd0 && pressed_flag[idx]) begin
          emit_msg = ked_pkg::MSG_REPEAT;
          emit     = rep_hit;
        end else if (pc == 4'd0) begin
          emit_msg = ked_pkg::MSG_LIFT;
          emit     = lift_hit;
        end
      end
      default: ;
    endcase
  end

  assign gen      = cmd.exec && emit;
  assign out_free = !out_valid || out_ready;

  assign status.slot_ok    = !pend_valid || out_free;
  assign status.pend_valid = pend_valid;
  assign status.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick        <= '0;
      prev_levels <= '1;
      for (int i = 0; i < NUM_KEYS; i++) begin
        change_time[i]  <= '0;
        press_count[i]  <= '0;
        pressed_flag[i] <= 1'b0;
        hold_flag[i]    <= 1'b0;
        lift_flag[i]    <= 1'b0;
      end
    end else begin
      if (cmd.accept) begin
        tick <= tick + 16'd1;
      end
      if (cmd.exec) begin
        case (cmd.step)
          ked_pkg::STEP_EDGE: begin
            if (cur != prev) begin
              if (!beyond) prev_levels[key_lo] <= cur;
              if (!cur) begin
                press_count[idx]  <= pc + 4'd1;
                pressed_flag[idx] <= 1'b1;
              end else begin
                pressed_flag[idx] <= 1'b0;
              end
              change_time[idx] <= tick;
            end
          end
          ked_pkg::STEP_TIME1: begin
            if (pc != 4'd0) begin
              if (pressed_flag[idx]) begin
                if (hold_hit) hold_flag[idx] <= 1'b1;
              end else if (close_hit) begin
                if (hold_flag[idx]) hold_flag[idx] <= 1'b0;
                press_count[idx] <= '0;
                lift_flag[idx]   <= 1'b0;
              end
            end
          end
          ked_pkg::STEP_TIME2: begin
            if (pc != 4'd0 && pressed_flag[idx]) begin
              if (rep_hit) begin
                change_time[idx] <= tick - cfg.hold_ticks;
                hold_flag[idx]   <= 1'b1;
              end
            end else if (pc == 4'd0) begin
              if (lift_hit) lift_flag[idx] <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // input latch and age snapshot, payload only
  always_ff @(posedge clk) begin
    if (cmd.accept) lvl <= key_levels;
    if (cmd.exec && cmd.step == ked_pkg::STEP_TIME1) age_reg <= age_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (gen) pend_valid <= 1'b1;
      else if (cmd.flush) pend_valid <= 1'b0;
      if ((gen && pend_valid) || cmd.flush) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen) begin
      pend_key <= key_lo;
      pend_msg <= emit_msg;
    end
    if ((gen && pend_valid) || cmd.flush) begin
      key_index <= pend_key;
      message   <= pend_msg;
      last      <= cmd.flush;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/key_event_detector.sv
// top level: multi-click and long-press key event detector
// sequence: from accept to the last message and back to idle, the block runs
//   one edge step and two timing steps per key on the shared compare datapath, plus a flush
// items: a new one is taken only once the last is through; steps wait while the result side stalls
// results: up to three messages per key, one per cycle while out_ready holds, the last of an item marked by last
// reset: synchronous, active high; thresholds return to their defaults, tick and key state clear
`timescale 1ns / 1ps
`default_nettype none

module key_event_detector #(
  parameter int NUM_KEYS   = ked_pkg::NUM_KEYS_DEF,
  parameter int MAX_CLICKS = ked_pkg::MAX_CLICKS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // tick items
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [3:0]        key_levels,
  // message items
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             key_index,
  output ked_pkg::msg_t          message,
  output logic                   last,
  // register writes
  input  wire logic              cfg_write,
  input  wire ked_pkg::reg_idx_t cfg_index,
  input  wire logic [31:0]       cfg_data
);

  // thresholds and enable bits, shared by every key
  ked_pkg::cfg_t    cfg;
  // controller to datapath: which step, which key, accept and flush strobes
  ked_pkg::cmd_t    cmd;
  // datapath to controller: room on the result side
  ked_pkg::status_t status;

  ked_cfg_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: idle, edge pass over all keys, then hold/close and repeat/lift per key,
  // then a flush that marks the held-back message as the last of the item
  ked_ctrl #(
    .NUM_KEYS (NUM_KEYS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // one message sits in a pending slot until the next one (or the flush) decides its last bit,
  // then moves to the output register; a step waits only when both are full and out_ready is low
  ked_datapath #(
    .NUM_KEYS   (NUM_KEYS),
    .MAX_CLICKS (MAX_CLICKS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg        (cfg),
    .key_levels (key_levels),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .key_index  (key_index),
    .message    (message),
    .last       (last)
  );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// testbench for the key event detector: random tick items checked against a built-in predictor
`timescale 1ns / 1ps

module tb_top;
  import ked_pkg::*;

  localparam int KEYS        = NUM_KEYS_DEF;
  // margin for the last item to pass through the block and for the block to go idle before a write
  localparam int SETTLE      = 2 + 3 * KEYS + 6;
  localparam int QUIET_LIMIT = 2000;

  // directed opening under short thresholds, first item in the top digit
  localparam int OPENING_LEN = 28;
  localparam logic [4*OPENING_LEN-1:0] OPENING = 112'hFFF00000FF_EFEFEFEFFF_5F5F5FFF;

  // one message as the block should report it
  typedef struct packed {
    logic [1:0] key;
    msg_t       msg;
    logic       last;
  } key_note_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [3:0]  key_levels = 4'hF;
  logic        out_ready = 1'b0;
  logic        cfg_write = 1'b0;
  reg_idx_t    cfg_index = REG_EVENT_ENABLE;
  logic [31:0] cfg_data = 32'd0;

  logic        in_ready;
  logic        out_valid;
  logic [1:0]  key_index;
  msg_t        message;
  logic        last;

  // no idling on either side while this is set
  logic        calm = 1'b0;
  int          fail_count = 0;
  int          quiet_cycles = 0;
  int          queued_total = 0;

  logic [3:0]  pending_ticks[$];
  key_note_t   awaited_msgs[$];
  key_note_t   tick_batch[$];

  // register copies kept in step with every write
  logic [31:0] en_mask;
  logic [15:0] t_hold;
  logic [15:0] t_rep;
  logic [15:0] t_rel;
  logic [15:0] t_lift;

  // key state as the block should hold it
  logic [15:0] tick_now;
  logic [3:0]  prev_lv;
  logic [15:0] t_change[KEYS];
  logic [3:0]  n_press[KEYS];
  logic        is_down[KEYS];
  logic        held[KEYS];
  logic        lifted[KEYS];

  key_event_detector uut (
    .clk,
    .rst,
    .in_valid,
    .in_ready,
    .key_levels,
    .out_valid,
    .out_ready,
    .key_index,
    .message,
    .last,
    .cfg_write,
    .cfg_index,
    .cfg_data
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic void clear_model();
    en_mask  = EVENT_ENABLE_RESET;
    t_hold   = HOLD_TICKS_RESET;
    t_rep    = REPEAT_TICKS_RESET;
    t_rel    = RELEASE_TICKS_RESET;
    t_lift   = LIFT_TICKS_RESET;
    tick_now = 16'd0;
    prev_lv  = 4'hF;
    for (int k = 0; k < KEYS; k++) begin
      t_change[k] = 16'd0;
      n_press[k]  = 4'd0;
      is_down[k]  = 1'b0;
      held[k]     = 1'b0;
      lifted[k]   = 1'b0;
    end
  endfunction

  // enable bit key*8+code, keys past bit 31 stay silent
  function automatic logic msg_on(input int k, input msg_t m);
    int b;
    b = k * 8 + int'(m);
    if (b >= 32) return 1'b0;
    return en_mask[b];
  endfunction

  function automatic void offer(input int k, input msg_t m);
    key_note_t n;
    n.key  = k[1:0];
    n.msg  = m;
    n.last = 1'b0;
    if (msg_on(k, m)) tick_batch.push_back(n);
  endfunction

  // works out every message one scan tick causes and queues them in order
  function automatic void decode_tick(input logic [3:0] lv);
    logic [15:0] age;
    tick_batch.delete();
    tick_now = tick_now + 16'd1;

    // level changes first: down or up, restart the key's clock
    for (int k = 0; k < KEYS; k++) begin
      if (lv[k] != prev_lv[k]) begin
        if (!lv[k]) begin
          n_press[k] = n_press[k] + 4'd1;
          offer(k, MSG_DOWN);
          is_down[k] = 1'b1;
        end else begin
          offer(k, MSG_UP);
          is_down[k] = 1'b0;
        end
        t_change[k] = tick_now;
      end
    end
    prev_lv = lv;

    // timing pass, age taken once per key before any update
    for (int k = 0; k < KEYS; k++) begin
      age = tick_now - t_change[k];
      if (n_press[k] != 4'd0) begin
        if (is_down[k]) begin
          if (msg_on(k, MSG_HOLD) && !held[k] && age >= t_hold) begin
            offer(k, MSG_HOLD);
            held[k] = 1'b1;
          end
          // threshold sum compared at 17 bits so it never wraps
          if (msg_on(k, MSG_REPEAT) && age >= t_hold &&
              {1'b0, age} >= {1'b0, t_hold} + {1'b0, t_rep}) begin
            offer(k, MSG_REPEAT);
            t_change[k] = tick_now - t_hold;
            held[k] = 1'b1;
          end
        end else if (age >= t_rel) begin
          // sequence closes: no click after a hold or past the click limit
          if (held[k]) begin
            held[k] = 1'b0;
          end else if (n_press[k] <= MAX_CLICKS_DEF && n_press[k] <= CLICK_LIMIT) begin
            offer(k, msg_t'(MSG_CLICK1 + n_press[k] - 4'd1));
          end
          n_press[k] = 4'd0;
          lifted[k]  = 1'b0;
        end
      end
      // a wrapped press count looks idle even while the key is down
      if (n_press[k] == 4'd0 && msg_on(k, MSG_LIFT) && !lifted[k] && age >= t_lift) begin
        offer(k, MSG_LIFT);
        lifted[k] = 1'b1;
      end
    end

    if (tick_batch.size() != 0) tick_batch[tick_batch.size() - 1].last = 1'b1;
    foreach (tick_batch[i]) awaited_msgs.push_back(tick_batch[i]);
  endfunction

  // puts a register write on the bus at the next edge, copy kept alongside
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_EVENT_ENABLE:  en_mask = val;
      REG_HOLD_TICKS:    t_hold  = val[15:0];
      REG_REPEAT_TICKS:  t_rep   = val[15:0];
      REG_RELEASE_TICKS: t_rel   = val[15:0];
      REG_LIFT_TICKS:    t_lift  = val[15:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_timing(input logic [31:0] en, input logic [31:0] hold_t,
                            input logic [31:0] rep_t, input logic [31:0] rel_t,
                            input logic [31:0] lift_t);
    write_reg(REG_EVENT_ENABLE, en);
    write_reg(REG_HOLD_TICKS, hold_t);
    write_reg(REG_REPEAT_TICKS, rep_t);
    write_reg(REG_RELEASE_TICKS, rel_t);
    write_reg(REG_LIFT_TICKS, lift_t);
    end_writes();
  endtask

  function automatic logic [31:0] pick_mask();
    int r;
    r = $urandom_range(7);
    if (r == 0) return 32'd0;
    if (r <= 2) return $urandom();
    return 32'hFFFF_FFFF;
  endfunction

  function automatic void queue_tick(input logic [3:0] lv);
    pending_ticks.push_back(lv);
    queued_total++;
  endfunction

  // a click sequence on one key, other keys parked at a fixed level
  function automatic void add_press_run(input int k, input int presses);
    logic [3:0] rest;
    logic [3:0] pressed;
    int down_len;
    int up_len;
    rest = 4'hF;
    if ($urandom_range(3) == 0) rest = 4'($urandom_range(15));
    rest[k] = 1'b1;
    pressed = rest;
    pressed[k] = 1'b0;
    for (int i = 0; i < presses; i++) begin
      down_len = $urandom_range(1, 2);
      // now and then long enough for hold and a few repeats
      if ($urandom_range(4) == 0) down_len = int'(t_hold) + int'(t_rep) * $urandom_range(3) + 1;
      if (down_len > 40) down_len = 40;
      // short gaps keep the sequence open unless the release threshold is zero, the last gap lets it close
      up_len = (t_rel > 16'd1) ? $urandom_range(1, int'(t_rel) - 1) : 1;
      if (i == presses - 1) up_len = int'(t_rel) + $urandom_range(0, int'(t_lift) + 1);
      if (up_len > 30) up_len = 30;
      repeat (down_len) queue_tick(pressed);
      repeat (up_len) queue_tick(rest);
    end
  endfunction

  // mostly well-formed click sequences, the rest random level noise
  function automatic void fill_random(input int target);
    int start;
    int presses;
    start = queued_total;
    while (queued_total - start < target) begin
      if ($urandom_range(9) < 7) begin
        presses = $urandom_range(1, 4);
        add_press_run($urandom_range(KEYS - 1), presses);
      end else begin
        repeat ($urandom_range(1, 4)) queue_tick(4'($urandom_range(15)));
      end
    end
  endfunction

  // let every queued item through, then give the block time to go idle
  task automatic run_phase();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || in_valid || awaited_msgs.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // tick driver: predicts on accept, holds the item until it is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) decode_tick(key_levels);
      if (!in_valid || in_ready) begin
        if (pending_ticks.size() != 0 && (calm || $urandom_range(99) >= 18)) begin
          in_valid   <= 1'b1;
          key_levels <= pending_ticks.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // message monitor: every accepted item against the oldest expectation
  always @(posedge clk) begin : msg_check
    key_note_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_msgs.size() == 0) begin
          report_mismatch($sformatf("unexpected message key %0d code %0d last %0b",
                                    key_index, message, last));
        end else begin
          want = awaited_msgs.pop_front();
          if (key_index !== want.key)
            report_mismatch($sformatf("key_index %0d, wanted %0d", key_index, want.key));
          if (message !== want.msg)
            report_mismatch($sformatf("message %0d, wanted %0d (key %0d)",
                                      message, want.msg, want.key));
          if (last !== want.last)
            report_mismatch($sformatf("last %0b, wanted %0b (key %0d code %0d)",
                                      last, want.last, want.key, want.msg));
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 18);
    end
  end

  // watchdog on stretches with no item moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    int k;
    clear_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // default thresholds, only the enables opened
    write_reg(REG_EVENT_ENABLE, 32'hFFFF_FFFF);
    end_writes();
    queue_tick(4'h0);
    queue_tick(4'hF);
    run_phase();

    // short thresholds: clicks close, lift, hold then repeat, release after a hold,
    // four clicks with no message, a triple click on two keys at once
    set_timing(32'hFFFF_FFFF, 32'd3, 32'd1, 32'd2, 32'd3);
    for (int i = OPENING_LEN - 1; i >= 0; i--) queue_tick(OPENING[i*4 +: 4]);
    run_phase();

    // all thresholds zero: every key can give down, hold and repeat in one tick
    set_timing(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0);
    queue_tick(4'h0);
    queue_tick(4'hF);
    queue_tick(4'h0);
    queue_tick(4'h0);
    queue_tick(4'hF);
    repeat (6) queue_tick(4'($urandom_range(15)));
    run_phase();

    // top values with upper data bits set, threshold sum past 16 bits,
    // then writes to unused indexes that must change nothing
    set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = REG_LIFT_TICKS + 1; i < (1 << $bits(reg_idx_t)); i++) begin
      write_reg(reg_idx_t'(i), $urandom());
    end
    end_writes();
    queue_tick(4'h0);
    queue_tick(4'hF);
    repeat (4) queue_tick(4'($urandom_range(15)));
    run_phase();

    // random settings with small thresholds, the second one with no idling
    for (int p = 0; p < 2; p++) begin
      set_timing(pick_mask(), $urandom_range(8), $urandom_range(4), $urandom_range(6),
                 $urandom_range(12));
      calm = (p == 1);
      fill_random(1);
      run_phase();
    end
    calm = 1'b0;

    // fifteen quick presses, then a long one that wraps the count and lets lift fire while down
    set_timing(32'hFFFF_FFFF, 32'd8, 32'd3, 32'd4, 32'd6);
    k = $urandom_range(KEYS - 1);
    for (int i = 0; i < 17; i++) begin
      repeat ((i == 15) ? 8 : 1) queue_tick(~(4'd1 << k));
      queue_tick(4'hF);
    end
    repeat (10) queue_tick(4'hF);
    run_phase();

    if (awaited_msgs.size() != 0) begin
      report_mismatch($sformatf("%0d messages never arrived", awaited_msgs.size()));
    end
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ked_pkg.sv
rtl/ked_cfg_regs.sv
rtl/ked_ctrl.sv
rtl/ked_datapath.sv
rtl/key_event_detector.sv
sim/tb_top.sv
